[hdl/whp_pkg.sv]
// shared types, codes and constants of the wbmp header parser
`timescale 1ns / 1ps
package whp_pkg;

	// field widths
	localparam int DIM_W    = 24;
	localparam int HDR_W    = 4;
	localparam int TOTAL_W  = 46;
	localparam int ACC_W    = 32;
	localparam int STATUS_W = 2;

	// defaults for top level parameters
	localparam int MAX_VALUE_BYTES_DEF = 5;
	localparam int QUEUE_DEPTH_DEF     = 4;

	// header window limits
	localparam logic [HDR_W-1:0] HDR_WINDOW = 4'd12;
	localparam logic [HDR_W-1:0] HDR_MIN    = 4'd4;
	localparam logic [HDR_W-1:0] HDR_SAT    = 4'd15;

	// reset value of the dimension limit
	localparam logic [DIM_W-1:0] MAX_DIM_RESET = 24'd65535;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CORRUPT     = 2'd3;

	// parsed header handed from front to back
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic [HDR_W-1:0]    hdr_len;
	} job_t;

	// finished result
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic [HDR_W-1:0]    hdr_len;
		logic [TOTAL_W-1:0]  total;
	} result_t;

endpackage

[hdl/whp_fifo.sv]
// small register queue with full and empty flags
`timescale 1ns / 1ps
module whp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// flags and transfer qualifiers
	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/whp_front.sv]
// byte parser: walks the header and issues one job per file
`timescale 1ns / 1ps
module whp_front
	import whp_pkg::*;
#(
	parameter int MAX_VALUE_BYTES = MAX_VALUE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [DIM_W-1:0] cfg_wr_data,
	input  logic             byte_valid,
	input  logic [7:0]       data_byte,
	input  logic             first_of_file,
	input  logic             end_of_data,
	output logic             job_valid,
	output job_t             job
);

	localparam logic [2:0] PH_TYPE    = 3'd0;
	localparam logic [2:0] PH_FIX     = 3'd1;
	localparam logic [2:0] PH_WIDTH   = 3'd2;
	localparam logic [2:0] PH_HEIGHT  = 3'd3;
	localparam logic [2:0] PH_BADTYPE = 3'd4;
	localparam logic [2:0] MAX_BYTES  = 3'(MAX_VALUE_BYTES);

	logic [DIM_W-1:0] max_dim_q;
	logic [2:0]       phase_q, phase_c, phase_n;
	logic [ACC_W-1:0] acc_q, acc_c, acc_n, acc_shift;
	logic [2:0]       biv_q, biv_c, biv_n;
	logic [HDR_W-1:0] hbs_q, hbs_c, hbs_n;
	logic [DIM_W-1:0] wid_q, wid_c, wid_n;
	logic             fin_q, fin_c, fin_n;
	logic             emit;
	logic [STATUS_W-1:0] code;
	logic             ok;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dim_q <= MAX_DIM_RESET;
		end else if (cfg_wr_en) begin
			max_dim_q <= cfg_wr_data;
		end
	end

	// a start mark clears the parse state first
	always_comb begin
		if (first_of_file) begin
			phase_c = PH_TYPE;
			acc_c   = '0;
			biv_c   = '0;
			hbs_c   = '0;
			wid_c   = '0;
			fin_c   = 1'b0;
		end else begin
			phase_c = phase_q;
			acc_c   = acc_q;
			biv_c   = biv_q;
			hbs_c   = hbs_q;
			wid_c   = wid_q;
			fin_c   = fin_q;
		end
	end

	assign acc_shift = {acc_c[ACC_W-8:0], data_byte[6:0]};

	// per byte parse step
	always_comb begin
		phase_n = phase_c;
		acc_n   = acc_c;
		biv_n   = biv_c;
		hbs_n   = hbs_c;
		wid_n   = wid_c;
		fin_n   = fin_c;
		emit    = 1'b0;
		code    = ST_OK;
		ok      = 1'b0;
		if (!fin_c) begin
			if (hbs_c < HDR_SAT) begin
				hbs_n = hbs_c + 1'b1;
			end
			unique case (phase_c)
				PH_TYPE: begin
					phase_n = (data_byte != 8'd0) ? PH_BADTYPE : PH_FIX;
					if (end_of_data) begin
						emit = 1'b1;
						code = ST_UNDERFLOW;
					end
				end
				PH_FIX: begin
					phase_n = PH_WIDTH;
					if (end_of_data) begin
						emit = 1'b1;
						code = ST_UNDERFLOW;
					end
				end
				PH_BADTYPE: begin
					if (hbs_n >= HDR_MIN) begin
						emit = 1'b1;
						code = ST_UNSUPPORTED;
					end else if (end_of_data) begin
						emit = 1'b1;
						code = ST_UNDERFLOW;
					end
				end
				PH_WIDTH, PH_HEIGHT: begin
					if (biv_c >= MAX_BYTES) begin
						emit = 1'b1;
						code = ST_CORRUPT;
					end else if (acc_shift > {{(ACC_W-DIM_W){1'b0}}, max_dim_q}) begin
						acc_n = acc_shift;
						emit  = 1'b1;
						code  = ST_CORRUPT;
					end else begin
						acc_n = acc_shift;
						biv_n = biv_c + 1'b1;
						if (!data_byte[7] && phase_c == PH_HEIGHT) begin
							emit = 1'b1;
							ok   = 1'b1;
							code = ST_OK;
						end else begin
							if (!data_byte[7]) begin
								wid_n   = acc_shift[DIM_W-1:0];
								acc_n   = '0;
								biv_n   = '0;
								phase_n = PH_HEIGHT;
							end
							if (end_of_data || hbs_n >= HDR_WINDOW) begin
								emit = 1'b1;
								code = ST_UNDERFLOW;
							end
						end
					end
				end
				default: begin
					emit = 1'b1;
					code = ST_CORRUPT;
				end
			endcase
			if (emit) begin
				fin_n = 1'b1;
			end
		end
	end

	// job record: dimensions and header length only on success
	always_comb begin
		job_valid   = byte_valid && emit;
		job.status  = code;
		job.width   = ok ? wid_c : '0;
		job.height  = ok ? acc_shift[DIM_W-1:0] : '0;
		job.hdr_len = ok ? hbs_n : '0;
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			acc_q   <= '0;
			biv_q   <= '0;
			hbs_q   <= '0;
			wid_q   <= '0;
			fin_q   <= 1'b0;
		end else if (byte_valid) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			biv_q   <= biv_n;
			hbs_q   <= hbs_n;
			wid_q   <= wid_n;
			fin_q   <= fin_n;
		end
	end

endmodule

[hdl/whp_back.sv]
// length unit: row bytes times height plus header, into the result queue
`timescale 1ns / 1ps
module whp_back
	import whp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_empty,
	input  job_t    job,
	output logic    job_pop,
	input  logic    res_pop,
	output logic    res_empty,
	output result_t res
);

	localparam int ROW_W = DIM_W - 2;

	logic               valid_s1;
	job_t               job_s1;
	logic [TOTAL_W-1:0] prod_s1;
	logic [DIM_W:0]     wid_ext;
	logic [ROW_W-1:0]   row_bytes;
	logic               res_full;
	logic               adv_s1;
	result_t            res_in;

	// bytes per row, rounded up
	assign wid_ext   = {1'b0, job.width} + (DIM_W+1)'(7);
	assign row_bytes = wid_ext[DIM_W:3];

	// stage handshakes
	assign adv_s1  = valid_s1 && !res_full;
	assign job_pop = !job_empty && (!valid_s1 || !res_full);

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (job_pop) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_s1  <= job;
			prod_s1 <= TOTAL_W'(row_bytes) * TOTAL_W'(job.height);
		end
	end

	// add the header length
	always_comb begin
		res_in.status  = job_s1.status;
		res_in.width   = job_s1.width;
		res_in.height  = job_s1.height;
		res_in.hdr_len = job_s1.hdr_len;
		res_in.total   = prod_s1 + {{(TOTAL_W-HDR_W){1'b0}}, job_s1.hdr_len};
	end

	// result queue
	whp_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (adv_s1),
		.wr_data (res_in),
		.full    (res_full),
		.pop     (res_pop),
		.rd_data (res),
		.empty   (res_empty)
	);

endmodule

[hdl/wbmp_header_parser_unit.sv]
// top level of the wbmp type 0 header parser
//
//  port group   direction  transfer on           payload
//  input bytes  in         push & !full          data_byte, first_of_file, end_of_data
//  results      out        pop & !empty          status, image_width, image_height,
//                                                header_length, total_length
//  config       in         cfg_wr_en             cfg_wr_data (max dimension)
//
// one byte is taken every cycle while full is low; the parser decides each byte in the cycle it is taken.
// a result passes from the job queue through the multiply stage into the result queue,
// and each of them holds it while the one after it is full.
// the multiply stage holds the 22 x 24 bit row length product.
// full rises only when the job queue is full, i.e. when results are not popped.
// arst_n clears all control state; max dimension returns to 65535.
`timescale 1ns / 1ps
module wbmp_header_parser_unit
	import whp_pkg::*;
#(
	parameter int MAX_VALUE_BYTES = MAX_VALUE_BYTES_DEF,
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [DIM_W-1:0]    cfg_wr_data,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          data_byte,
	input  logic                first_of_file,
	input  logic                end_of_data,
	input  logic                pop,
	output logic                empty,
	output logic [STATUS_W-1:0] status,
	output logic [DIM_W-1:0]    image_width,
	output logic [DIM_W-1:0]    image_height,
	output logic [HDR_W-1:0]    header_length,
	output logic [TOTAL_W-1:0]  total_length
);

	logic    byte_valid;
	logic    job_valid;
	job_t    job_in;
	job_t    job_out;
	logic    job_full;
	logic    job_empty;
	logic    job_pop;
	result_t res;

	// input transfer
	assign full       = job_full;
	assign byte_valid = push && !job_full;

	// front: header parser
	whp_front #(
		.MAX_VALUE_BYTES (MAX_VALUE_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.byte_valid    (byte_valid),
		.data_byte     (data_byte),
		.first_of_file (first_of_file),
		.end_of_data   (end_of_data),
		.job_valid     (job_valid),
		.job           (job_in)
	);

	// queue between parser and length unit
	whp_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_valid),
		.wr_data (job_in),
		.full    (job_full),
		.pop     (job_pop),
		.rd_data (job_out),
		.empty   (job_empty)
	);

	// back: length unit and result queue
	whp_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.res_pop   (pop),
		.res_empty (empty),
		.res       (res)
	);

	// result fields
	assign status        = res.status;
	assign image_width   = res.width;
	assign image_height  = res.height;
	assign header_length = res.hdr_len;
	assign total_length  = res.total;

endmodule

[test/tb.sv]
// self-checking testbench for the wbmp header parser unit
`timescale 1ns / 1ps
module tb;
	import whp_pkg::*;

	// one byte of the file stream as offered to the block
	typedef struct packed {
		logic [7:0] data;
		logic       sof;
		logic       eod;
	} file_byte_t;

	// where the header walk stands
	typedef enum logic [2:0] {
		AWAIT_TYPE,
		SKIP_FIXED,
		READ_WIDTH,
		READ_HEIGHT,
		BAD_TYPE
	} walk_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                cfg_wr_en     = 1'b0;
	logic [DIM_W-1:0]    cfg_wr_data   = '0;
	logic                push          = 1'b0;
	logic                full;
	logic [7:0]          data_byte     = '0;
	logic                first_of_file = 1'b0;
	logic                end_of_data   = 1'b0;
	logic                pop           = 1'b0;
	logic                empty;
	logic [STATUS_W-1:0] status;
	logic [DIM_W-1:0]    image_width;
	logic [DIM_W-1:0]    image_height;
	logic [HDR_W-1:0]    header_length;
	logic [TOTAL_W-1:0]  total_length;

	// parser model state
	walk_t            walk_now   = AWAIT_TYPE;
	logic [ACC_W-1:0] dim_acc    = '0;
	int               dim_bytes  = 0;
	logic [HDR_W-1:0] hdr_count  = '0;
	logic [DIM_W-1:0] held_width = '0;
	bit               file_done  = 1'b0;
	logic [DIM_W-1:0] dim_limit  = MAX_DIM_RESET;

	file_byte_t file_stream[$];
	result_t    parsed_headers[$];
	result_t    hdr_next;
	result_t    seen;
	result_t    want;
	int         bytes_taken = 0;
	int         send_gap    = 0;
	int         take_gap    = 0;
	int         fault_count = 0;
	bit         steady      = 1'b0;
	logic       rx_hold     = 1'b0;

	wbmp_header_parser_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.first_of_file (first_of_file),
		.end_of_data   (end_of_data),
		.pop           (pop),
		.empty         (empty),
		.status        (status),
		.image_width   (image_width),
		.image_height  (image_height),
		.header_length (header_length),
		.total_length  (total_length)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// walk one byte through the header; returns 1 when it yields a result
	function automatic bit parse_header_byte(input logic [7:0] b, input logic sof,
			input logic eod, output result_t hdr);
		bit          give;
		logic [63:0] tot;
		give = 1'b0;
		hdr  = '0;
		if (sof) begin
			walk_now   = AWAIT_TYPE;
			dim_acc    = '0;
			dim_bytes  = 0;
			hdr_count  = '0;
			held_width = '0;
			file_done  = 1'b0;
		end
		if (file_done)
			return 1'b0;
		if (hdr_count < HDR_SAT)
			hdr_count++;
		case (walk_now)
			AWAIT_TYPE: begin
				walk_now   = (b != 8'd0) ? BAD_TYPE : SKIP_FIXED;
				give       = eod;
				hdr.status = ST_UNDERFLOW;
			end
			SKIP_FIXED: begin
				walk_now   = READ_WIDTH;
				give       = eod;
				hdr.status = ST_UNDERFLOW;
			end
			BAD_TYPE: begin
				// the type error only shows once the minimum header has gone by
				give       = (hdr_count >= HDR_MIN) || eod;
				hdr.status = (hdr_count >= HDR_MIN) ? ST_UNSUPPORTED : ST_UNDERFLOW;
			end
			default: begin
				if (dim_bytes >= MAX_VALUE_BYTES_DEF) begin
					give       = 1'b1;
					hdr.status = ST_CORRUPT;
				end else begin
					dim_acc = {dim_acc[ACC_W-8:0], b[6:0]};
					if (dim_acc > dim_limit) begin
						give       = 1'b1;
						hdr.status = ST_CORRUPT;
					end else begin
						dim_bytes++;
						if (!b[7] && walk_now == READ_HEIGHT) begin
							// header complete
							tot = 64'(hdr_count) + ((64'(held_width) + 64'd7) >> 3)
								* 64'(dim_acc[DIM_W-1:0]);
							give        = 1'b1;
							hdr.status  = ST_OK;
							hdr.width   = held_width;
							hdr.height  = dim_acc[DIM_W-1:0];
							hdr.hdr_len = hdr_count;
							hdr.total   = tot[TOTAL_W-1:0];
						end else begin
							if (!b[7]) begin
								held_width = dim_acc[DIM_W-1:0];
								dim_acc    = '0;
								dim_bytes  = 0;
								walk_now   = READ_HEIGHT;
							end
							give       = eod || (hdr_count >= HDR_WINDOW);
							hdr.status = ST_UNDERFLOW;
						end
					end
				end
			end
		endcase
		if (give)
			file_done = 1'b1;
		else
			hdr = '0;
		return give;
	endfunction

	task automatic add_byte(input logic [7:0] d, input logic sof, input logic eod);
		file_stream.push_back({d, sof, eod});
	endtask

	// continuation-coded value, padded with leading zero groups up to min_bytes
	task automatic push_dim(input int unsigned v, input int min_bytes);
		int groups;
		groups = 1;
		while (groups < 5 && (v >> (7 * groups)) != 0)
			groups++;
		repeat (min_bytes - groups)
			add_byte(8'h80, 1'b0, 1'b0);
		for (int i = groups - 1; i >= 0; i--)
			add_byte({i != 0, 7'(v >> (7 * i))}, 1'b0, 1'b0);
	endtask

	// dimension biased towards the limit and its neighbours
	function automatic int unsigned pick_dim();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return dim_limit;
			2:       return 32'(dim_limit) + 1;
			3:       return $urandom_range(0, dim_limit);
			default: return $urandom_range(0, (dim_limit < 300) ? dim_limit : 300);
		endcase
	endfunction

	// one file: mostly well formed, some truncated, some with a bad type, some noise
	task automatic add_file();
		int         kind;
		int         start;
		int         cut;
		file_byte_t tmp;
		kind  = $urandom_range(0, 19);
		start = file_stream.size();
		if (kind == 18) begin
			repeat ($urandom_range(1, 6))
				add_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
		end else if (kind >= 16) begin
			add_byte(8'($urandom_range(1, 255)), 1'b1, 1'b0);
			repeat ($urandom_range(0, 5))
				add_byte(8'($urandom), 1'b0, $urandom_range(0, 4) == 0);
		end else begin
			add_byte(8'h00, 1'b1, 1'b0);
			add_byte(8'($urandom), 1'b0, 1'b0);
			if (kind == 19) begin
				// both values five bytes long: the header fills the whole window
				push_dim(pick_dim(), 5);
				push_dim(pick_dim(), 5);
				if ($urandom_range(0, 1) == 1) begin
					tmp = file_stream[file_stream.size() - 1];
					tmp.data[7] = 1'b1;
					file_stream[file_stream.size() - 1] = tmp;
				end
			end else begin
				push_dim(pick_dim(), ($urandom_range(0, 7) == 0) ? $urandom_range(2, 7) : 1);
				push_dim(pick_dim(), ($urandom_range(0, 7) == 0) ? $urandom_range(2, 7) : 1);
			end
			if (kind >= 14 && kind <= 15) begin
				// data ends somewhere inside the header
				cut = start + $urandom_range(0, file_stream.size() - start - 1);
				while (file_stream.size() > cut + 1)
					file_stream.delete(file_stream.size() - 1);
			end else begin
				cut = file_stream.size() - 1;
			end
			tmp = file_stream[cut];
			tmp.eod = (kind >= 14) ? 1'b1 : 1'(($urandom_range(0, 1)));
			file_stream[cut] = tmp;
			// trailing bytes that the block has to ignore
			repeat ($urandom_range(0, 2))
				add_byte(8'($urandom), 1'b0, $urandom_range(0, 1) == 1);
		end
	endtask

	task automatic log_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", what);
	endtask

	// wait until every byte is taken and every header has come back
	task automatic settle();
		do
			@(negedge clk);
		while (file_stream.size() != 0 || push || parsed_headers.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// byte sender: predicts on each transfer, then idles for send_gap, which stays zero while steady is set
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				if (parse_header_byte(data_byte, first_of_file, end_of_data, hdr_next))
					parsed_headers.push_back(hdr_next);
				file_stream.delete(0);
				bytes_taken++;
				send_gap = steady ? 0 : $urandom_range(0, 3);
			end
			if (!push || !full) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (file_stream.size() > 0) begin
					push          <= 1'b1;
					data_byte     <= file_stream[0].data;
					first_of_file <= file_stream[0].sof;
					end_of_data   <= file_stream[0].eod;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// result receiver: checks each transfer against the oldest predicted header
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				seen = {status, image_width, image_height, header_length, total_length};
				if (parsed_headers.size() == 0) begin
					log_fault($sformatf("unexpected result: status %0d width %0d height %0d",
						seen.status, seen.width, seen.height));
				end else begin
					want = parsed_headers.pop_front();
					if (seen.status != want.status || seen.width != want.width ||
							seen.height != want.height || seen.hdr_len != want.hdr_len ||
							seen.total != want.total)
						log_fault($sformatf({"header mismatch: expected st %0d w %0d h %0d ",
							"hdr %0d total %0d, got st %0d w %0d h %0d hdr %0d total %0d"},
							want.status, want.width, want.height, want.hdr_len, want.total,
							seen.status, seen.width, seen.height, seen.hdr_len, seen.total));
				end
				take_gap = steady ? 0 : $urandom_range(0, 3);
			end
			if (rx_hold) begin
				pop <= 1'b0;
			end else if (!pop || !empty) begin
				if (take_gap > 0) begin
					take_gap--;
					pop <= 1'b0;
				end else begin
					pop <= 1'b1;
				end
			end
		end
	end

	// one long receiver stall so that the block backs up and raises full
	initial begin
		wait (bytes_taken >= 700);
		@(posedge clk) rx_hold <= 1'b1;
		repeat (600) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// stimulus
	initial begin
		int unsigned lim;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no start mark after reset, header with zero width and height
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'hFF, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0);
		// ignored after a result, even with end of data
		add_byte(8'hFF, 1'b0, 1'b1);
		// unsupported type, reported at the fourth byte
		add_byte(8'hFF, 1'b1, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'h7F, 1'b0, 1'b0);
		add_byte(8'h80, 1'b0, 1'b0);
		// data ends on the fixed-header byte
		add_byte(8'h00, 1'b1, 1'b0);
		add_byte(8'h00, 1'b0, 1'b1);
		// header window full with another byte still asked for
		add_byte(8'h00, 1'b1, 1'b0);
		add_byte(8'h5A, 1'b0, 1'b0);
		repeat (4) add_byte(8'h80, 1'b0, 1'b0);
		add_byte(8'h01, 1'b0, 1'b0);
		repeat (4) add_byte(8'h80, 1'b0, 1'b0);
		add_byte(8'h81, 1'b0, 1'b0);
		settle();

		// random files under a range of dimension limits
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       lim = 24'hFFFFFF;
				1:       lim = 0;
				2:       lim = 127;
				3:       lim = $urandom_range(128, 24'hFFFFFF);
				4:       lim = MAX_DIM_RESET;
				default: lim = 1;
			endcase
			steady = (ph == 3);
			@(posedge clk);
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= lim[DIM_W-1:0];
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			dim_limit = lim[DIM_W-1:0];
			@(negedge clk);
			while (file_stream.size() < 283)
				add_file();
			settle();
		end

		if (fault_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// run time limit
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
hdl/whp_pkg.sv
hdl/whp_fifo.sv
hdl/whp_front.sv
hdl/whp_back.sv
hdl/wbmp_header_parser_unit.sv
test/tb.sv
